// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- src/chte_pkg.sv -----
// shared constants, types and helpers for the hash table engine
package chte_pkg;
    localparam int DEF_MAX_BUCKETS = 64;
    localparam int DEF_CHAIN_SLOTS = 4;
    localparam int DEF_KEY_CHARS = 8;
    localparam int DEF_WINDOW_CHARS = 4;
    localparam logic [16:0] HASH_MOD = 17'd65407;
    localparam logic [6:0] BUCKETS_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_GET = 2'd0,
        OP_PUT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_SPARE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_FOUND = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INSERTED = 3'd2,
        ST_UPDATED = 3'd3,
        ST_FULL = 3'd4,
        ST_BAD_KEY = 3'd5
    } status_t;

    // handshake between the top level and the hash unit
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } hash_ctl_t;

    // letters and digits are valid; letters give 0..25, digits 0..9 and are handled separately
    function automatic logic char_ok(input logic [7:0] c);
        char_ok = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
            || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic char_digit(input logic [7:0] c);
        char_digit = (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic [4:0] char_offset(input logic [7:0] c);
        logic [7:0] d;
        if (c >= 8'h61) d = c - 8'h61;
        else if (c >= 8'h41) d = c - 8'h41;
        else d = c - 8'h30;
        char_offset = d[4:0];
    endfunction

    // x < 2*HASH_MOD reduced once
    function automatic logic [15:0] mod_once(input logic [16:0] x);
        logic [16:0] t;
        t = (x >= HASH_MOD) ? x - HASH_MOD : x;
        mod_once = t[15:0];
    endfunction
endpackage

// ----- src/chte_hash.sv -----
// folding window hash, one character step per cycle
`include "assert_macros.svh"
module chte_hash
    import chte_pkg::*;
#(
    parameter int WINDOW_CHARS = DEF_WINDOW_CHARS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [63:0] key_text,
    input  logic [3:0] key_length,
    output hash_ctl_t ctl,
    output logic [15:0] hash
);
    logic busy_reg, done_reg;
    logic [3:0] start_reg, pos_reg;
    logic [15:0] win_reg, sum_reg;
    logic [7:0] c;
    logic [20:0] prod;
    logic [20:0] step;
    logic [15:0] win_next;
    logic [3:0] win_end;
    logic last_win;

    assign c = key_text[8*pos_reg[2:0] +: 8];
    assign prod = char_digit(c) ? 21'(win_reg) * 21'd9 : 21'(win_reg) * 21'd26;
    assign step = prod + 21'(char_offset(c));
    // 2^16 is 129 modulo 65407, so fold the high bits back in and reduce once
    assign win_next = mod_once(17'(step[15:0]) + 17'(step[20:16]) * 17'd129);
    assign win_end = ((start_reg + 4'(WINDOW_CHARS)) > key_length)
        ? key_length : start_reg + 4'(WINDOW_CHARS);
    assign last_win = (start_reg + 4'd1 >= key_length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            start_reg <= '0;
            pos_reg <= '0;
            win_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            if (start)
            begin
                start_reg <= '0;
                pos_reg <= '0;
                win_reg <= '0;
                sum_reg <= '0;
                busy_reg <= (key_length != 4'd0);
                done_reg <= (key_length == 4'd0);
            end
            else if (busy_reg)
            begin
                if (pos_reg + 4'd1 >= win_end)
                begin
                    sum_reg <= mod_once({1'b0, sum_reg} + {1'b0, win_next});
                    win_reg <= '0;
                    busy_reg <= !last_win;
                    done_reg <= last_win;
                    start_reg <= start_reg + 4'd1;
                    pos_reg <= start_reg + 4'd1;
                end
                else
                begin
                    win_reg <= win_next;
                    pos_reg <= pos_reg + 4'd1;
                    done_reg <= 1'b0;
                end
            end
            else done_reg <= 1'b0;
        end
    end

    assign ctl = '{start: start, busy: busy_reg, done: done_reg};
    assign hash = sum_reg;

    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg || start)
    `ASSERT_IMPLIES(a_not_both, clk, rst_n, busy_reg, !done_reg)
    `ASSERT_IMPLIES(a_sum_range, clk, rst_n, 1'b1, {1'b0, sum_reg} < HASH_MOD)
endmodule

// ----- src/chained_hash_table_engine_top.sv -----
// top level: request sequencer, bucket reduction, chain walk and slot memory
// steps: check, hash, bucket reduction, fill count load, chain walk, last slot read,
//   then a table write on an insert, an update or a remove hit
// one request at a time: in_stall holds until the result is taken
// bad keys are answered straight from the check state, no hash
// reset: bucket count back to 64, then a pass clearing every fill count, input stalled
`include "assert_macros.svh"
module chained_hash_table_engine_top
    import chte_pkg::*;
#(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int CHAIN_SLOTS = DEF_CHAIN_SLOTS,
    parameter int KEY_CHARS = DEF_KEY_CHARS,
    parameter int WINDOW_CHARS = DEF_WINDOW_CHARS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [6:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic [1:0] op,
    input  logic [63:0] key_text,
    input  logic [3:0] key_length,
    input  logic [63:0] entry_value,
    output logic out_valid,
    input  logic out_stall,
    output logic [2:0] status,
    output logic [63:0] read_value,
    output logic [5:0] bucket_index
);
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SW = (CHAIN_SLOTS > 1) ? $clog2(CHAIN_SLOTS) : 1;
    localparam int FW = $clog2(CHAIN_SLOTS + 1);
    localparam int DEPTH = MAX_BUCKETS * (1 << SW);
    localparam int AW = BW + SW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_HASH, S_MOD, S_FILL, S_LOAD, S_READ, S_CMP,
        S_LAST, S_MOVE, S_WRITE, S_OUT
    } state_t;

    state_t state_reg;
    logic [6:0] nb_reg;
    logic [1:0] op_reg;
    logic [63:0] key_reg, val_reg;
    logic [3:0] len_reg;
    logic [15:0] rem_reg;
    logic [4:0] mod_cnt_reg;
    logic [BW-1:0] bucket_reg;
    logic [BW-1:0] clr_reg;
    logic [FW-1:0] fill_reg;
    logic [SW:0] idx_reg;
    logic [SW-1:0] hit_reg;
    logic hit_ok_reg;
    logic [FW-1:0] fill_mem [MAX_BUCKETS];
    logic [FW-1:0] fill_rd_reg;
    logic fill_we;
    logic [BW-1:0] fill_waddr;
    logic [FW-1:0] fill_wdata;
    logic [63:0] key_mem [DEPTH];
    logic [3:0] len_mem [DEPTH];
    logic [63:0] val_mem [DEPTH];
    logic [63:0] rd_key_reg, rd_val_reg;
    logic [3:0] rd_len_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic rd_en, wr_en;
    logic [63:0] wr_key, wr_val;
    logic [3:0] wr_len;
    logic [63:0] mov_key_reg, mov_val_reg;
    logic [3:0] mov_len_reg;
    logic [2:0] status_reg;
    logic [63:0] rval_reg;
    logic out_valid_reg;
    logic hash_start;
    hash_ctl_t hctl;
    logic [15:0] hash;
    logic [63:0] key_masked;
    logic [3:0] len_sat;
    logic key_bad;
    logic [6:0] nb_eff;
    logic [15:0] nb_sh;

    always_comb
    begin
        len_sat = (key_length > 4'(KEY_CHARS)) ? 4'(KEY_CHARS) : key_length;
        for (int i = 0; i < 8; i++)
            key_masked[8*i +: 8] = (4'(i) < len_sat) ? key_text[8*i +: 8] : 8'h00;
    end

    always_comb
    begin
        key_bad = 1'b0;
        for (int i = 0; i < 8; i++)
            if (4'(i) < len_reg && !char_ok(key_reg[8*i +: 8])) key_bad = 1'b1;
    end

    assign nb_eff = (nb_reg == 7'd0) ? 7'd1
        : ((32'(nb_reg) > MAX_BUCKETS) ? 7'(MAX_BUCKETS) : nb_reg);
    // restoring reduction: subtract nb shifted left by the step count
    assign nb_sh = 16'(nb_eff) << mod_cnt_reg[3:0];

    chte_hash #(.WINDOW_CHARS(WINDOW_CHARS)) u_hash (
        .clk(clk), .rst_n(rst_n), .start(hash_start), .key_text(key_reg),
        .key_length(len_reg), .ctl(hctl), .hash(hash)
    );

    assign hash_start = (state_reg == S_CHECK) && !key_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) nb_reg <= BUCKETS_RESET;
        else if (cfg_we) nb_reg <= cfg_data;
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            len_mem[wr_addr] <= wr_len;
            val_mem[wr_addr] <= wr_val;
        end
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_len_reg <= len_mem[rd_addr];
            rd_val_reg <= val_mem[rd_addr];
        end
    end

    // fill counts, cleared by a pass after reset
    always_ff @(posedge clk)
    begin
        if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
        if (state_reg == S_FILL) fill_rd_reg <= fill_mem[BW'(rem_reg)];
    end

    always_comb
    begin
        fill_we = (state_reg == S_CLEAR)
            || (state_reg == S_WRITE && (status_reg == ST_INSERTED || op_reg == OP_REMOVE));
        fill_waddr = (state_reg == S_CLEAR) ? clr_reg : bucket_reg;
        if (state_reg == S_CLEAR) fill_wdata = '0;
        else if (op_reg == OP_REMOVE) fill_wdata = fill_reg - FW'(1);
        else fill_wdata = fill_reg + FW'(1);
    end

    assign rd_en = (state_reg == S_READ) || (state_reg == S_LAST);
    assign rd_addr = (state_reg == S_LAST)
        ? {bucket_reg, SW'(fill_reg - FW'(1))} : {bucket_reg, idx_reg[SW-1:0]};
    assign wr_en = (state_reg == S_WRITE);

    always_comb
    begin
        wr_addr = {bucket_reg, hit_reg};
        wr_key = key_reg;
        wr_len = len_reg;
        wr_val = val_reg;
        if (op_reg == OP_REMOVE)
        begin
            wr_key = mov_key_reg;
            wr_len = mov_len_reg;
            wr_val = mov_val_reg;
        end
        else if (!hit_ok_reg)
            wr_addr = {bucket_reg, SW'(fill_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            out_valid_reg <= 1'b0;
            clr_reg <= '0;
            op_reg <= '0;
            len_reg <= '0;
            key_reg <= '0;
            val_reg <= '0;
            rem_reg <= '0;
            mod_cnt_reg <= '0;
            bucket_reg <= '0;
            fill_reg <= '0;
            idx_reg <= '0;
            hit_reg <= '0;
            hit_ok_reg <= 1'b0;
            status_reg <= '0;
            rval_reg <= '0;
            mov_key_reg <= '0;
            mov_len_reg <= '0;
            mov_val_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + BW'(1);
                    if (clr_reg == BW'(MAX_BUCKETS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg <= op;
                        key_reg <= key_masked;
                        len_reg <= len_sat;
                        val_reg <= entry_value;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (key_bad)
                    begin
                        status_reg <= ST_BAD_KEY;
                        rval_reg <= '0;
                        bucket_reg <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else state_reg <= S_HASH;
                end
                S_HASH:
                begin
                    if (hctl.done)
                    begin
                        rem_reg <= hash;
                        mod_cnt_reg <= 5'd15;
                        state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    if ((32'(nb_eff) << mod_cnt_reg[3:0]) <= 32'(rem_reg))
                        rem_reg <= rem_reg - nb_sh;
                    if (mod_cnt_reg == 5'd0) state_reg <= S_FILL;
                    else mod_cnt_reg <= mod_cnt_reg - 5'd1;
                end
                S_FILL:
                begin
                    bucket_reg <= BW'(rem_reg);
                    idx_reg <= '0;
                    hit_ok_reg <= 1'b0;
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    fill_reg <= (32'(fill_rd_reg) > CHAIN_SLOTS)
                        ? FW'(CHAIN_SLOTS) : fill_rd_reg;
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    if (32'(idx_reg) >= 32'(fill_reg)) state_reg <= S_LAST;
                    else state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (rd_len_reg == len_reg && rd_key_reg == key_reg)
                    begin
                        hit_ok_reg <= 1'b1;
                        hit_reg <= idx_reg[SW-1:0];
                        rval_reg <= rd_val_reg;
                        state_reg <= S_LAST;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_LAST:
                    state_reg <= S_MOVE;
                S_MOVE:
                begin
                    mov_key_reg <= rd_key_reg;
                    mov_len_reg <= rd_len_reg;
                    mov_val_reg <= rd_val_reg;
                    if (op_reg == OP_PUT)
                    begin
                        rval_reg <= '0;
                        if (hit_ok_reg)
                        begin
                            status_reg <= ST_UPDATED;
                            state_reg <= S_WRITE;
                        end
                        else if (32'(fill_reg) >= CHAIN_SLOTS)
                        begin
                            status_reg <= ST_FULL;
                            out_valid_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            status_reg <= ST_INSERTED;
                            state_reg <= S_WRITE;
                        end
                    end
                    else if (op_reg == OP_REMOVE)
                    begin
                        rval_reg <= '0;
                        if (hit_ok_reg)
                        begin
                            status_reg <= ST_FOUND;
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            status_reg <= ST_NOT_FOUND;
                            out_valid_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        status_reg <= hit_ok_reg ? ST_FOUND : ST_NOT_FOUND;
                        if (!hit_ok_reg) rval_reg <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_WRITE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign read_value = rval_reg;
    assign bucket_index = 6'(bucket_reg);

    `ASSERT_IMPLIES(a_out_state, clk, rst_n, out_valid_reg, state_reg == S_OUT)
    `ASSERT_IMPLIES(a_busy_stall, clk, rst_n, state_reg != S_IDLE, in_stall)
    `ASSERT_NEXT(a_bad_zero, clk, rst_n, out_valid_reg && status_reg == ST_BAD_KEY,
        bucket_reg == '0 || !out_valid_reg)
    `ASSERT_IMPLIES(a_fill_bound, clk, rst_n, 1'b1, 32'(fill_reg) <= CHAIN_SLOTS)
endmodule

// ----- tb/tb_chained_hash_table_engine_top.sv -----
// testbench for the chained hash table engine: queued requests, predicted table, field checks
module tb_chained_hash_table_engine_top;
    import chte_pkg::*;

    localparam int NBKT = 64;
    localparam int NSLOT = 4;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        op_t op;
        logic [63:0] key;
        logic [3:0] len;
        logic [63:0] val;
    } request_t;

    typedef struct {
        status_t st;
        logic [63:0] rv;
        logic [5:0] bkt;
    } answer_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [6:0] cfg_data = 0;
    logic in_valid = 0;
    logic [1:0] op = 0;
    logic [63:0] key_text = 0;
    logic [3:0] key_length = 0;
    logic [63:0] entry_value = 0;
    logic out_stall = 0;
    logic in_stall, out_valid;
    logic [2:0] status;
    logic [63:0] read_value;
    logic [5:0] bucket_index;

    chained_hash_table_engine_top dut (.*);

    always #2 clk = ~clk;

    // predicted table contents
    logic [63:0] tbl_key [NBKT*NSLOT];
    logic [3:0] tbl_len [NBKT*NSLOT];
    logic [63:0] tbl_val [NBKT*NSLOT];
    int chain_len [NBKT];
    int active_buckets = 64;

    request_t pending_reqs[$];
    answer_t expected_answers[$];
    int mismatches = 0;
    int cycles = 0;
    int accepted = 0;
    int checked = 0;
    int in_gap = 0;
    int out_gap = 0;

    // small key pool so puts, gets and removes collide often
    logic [63:0] pool_key [24];
    logic [3:0] pool_len [24];

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(0, 61);
        if (r < 26) return 8'h41 + r[7:0];
        if (r < 52) return 8'h61 + r[7:0] - 8'd26;
        return 8'h30 + r[7:0] - 8'd52;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [16:0] fold_key(logic [63:0] k, int n);
        logic [16:0] sum, h;
        logic [7:0] c;
        sum = 0;
        for (int i = 0; i < n; i++)
        begin
            h = 0;
            for (int p = i; p < i + 4 && p < n; p++)
            begin
                c = k[8*p +: 8];
                if (c >= "A" && c <= "Z") h = (h * 26 + (c - "A")) % 65407;
                else if (c >= "a" && c <= "z") h = (h * 26 + (c - "a")) % 65407;
                else h = (h * 9 + (c - "0")) % 65407;
            end
            sum = (sum + h) % 65407;
        end
        return sum;
    endfunction

    function automatic answer_t table_lookup(request_t r);
        answer_t a;
        int n, nb, b, base, hit, fill;
        logic [63:0] k;
        logic [7:0] c;
        a.st = ST_FOUND;
        a.rv = 0;
        a.bkt = 0;
        n = (r.len > 8) ? 8 : r.len;
        k = (n == 8) ? r.key : (r.key & ((64'd1 << (8*n)) - 1));
        for (int p = 0; p < n; p++)
        begin
            c = k[8*p +: 8];
            if (!((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9")))
            begin
                a.st = ST_BAD_KEY;
                return a;
            end
        end
        nb = (active_buckets == 0) ? 1 : (active_buckets > NBKT ? NBKT : active_buckets);
        b = fold_key(k, n) % nb;
        a.bkt = b[5:0];
        base = b * NSLOT;
        fill = chain_len[b];
        hit = -1;
        for (int i = 0; i < fill; i++)
            if (hit < 0 && tbl_len[base+i] == n && tbl_key[base+i] == k) hit = i;
        if (r.op == OP_PUT)
        begin
            if (hit >= 0)
            begin
                tbl_val[base+hit] = r.val;
                a.st = ST_UPDATED;
            end
            else if (fill >= NSLOT) a.st = ST_FULL;
            else
            begin
                tbl_key[base+fill] = k;
                tbl_len[base+fill] = n[3:0];
                tbl_val[base+fill] = r.val;
                chain_len[b] = fill + 1;
                a.st = ST_INSERTED;
            end
        end
        else if (r.op == OP_REMOVE)
        begin
            if (hit >= 0)
            begin
                tbl_key[base+hit] = tbl_key[base+fill-1];
                tbl_len[base+hit] = tbl_len[base+fill-1];
                tbl_val[base+hit] = tbl_val[base+fill-1];
                chain_len[b] = fill - 1;
            end
            else a.st = ST_NOT_FOUND;
        end
        else if (hit >= 0) a.rv = tbl_val[base+hit];
        else a.st = ST_NOT_FOUND;
        return a;
    endfunction

    task automatic add_req(op_t o, logic [63:0] k, logic [3:0] n, logic [63:0] v);
        request_t r;
        r.op = o;
        r.key = k;
        r.len = n;
        r.val = v;
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_buckets(int v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v[6:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        active_buckets = v;
    endtask

    // driver
    always @(posedge clk)
    begin
        request_t r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                r.op = op_t'(op);
                r.key = key_text;
                r.len = key_length;
                r.val = entry_value;
                expected_answers = {expected_answers, table_lookup(r)};
                accepted++;
                in_gap = gap_len();
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    r = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    op <= r.op;
                    key_text <= r.key;
                    key_length <= r.len;
                    entry_value <= r.val;
                end
                else in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d bucket %0d", status, bucket_index);
                end
                else
                begin
                    e = expected_answers.pop_front();
                    checked++;
                    if (status !== e.st || read_value !== e.rv || bucket_index !== e.bkt)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp st %0d val %h bkt %0d, got st %0d val %h bkt %0d",
                                e.st, e.rv, e.bkt, status, read_value, bucket_index);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0) out_gap = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_answers.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int n, pick;
        logic [63:0] k;
        for (int b = 0; b < NBKT; b++) chain_len[b] = 0;
        for (int i = 0; i < 24; i++)
        begin
            n = $urandom_range(0, 8);
            k = {$urandom, $urandom};
            for (int p = 0; p < 8; p++) k[8*p +: 8] = rand_char();
            pool_key[i] = k;
            pool_len[i] = n[3:0];
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every op, empty key, long key, ignored bytes, bad key, spare op
        add_req(OP_GET, 64'h0, 4'd0, 64'h0);
        add_req(OP_PUT, 64'hFFFF_FFFF_FFFF_0000, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        add_req(OP_GET, 64'h0, 4'd0, 64'h0);
        add_req(OP_PUT, "zZ9a0Az9", 4'd8, 64'h1234);
        add_req(OP_PUT, "zZ9a0Az9", 4'd15, 64'h5678);
        add_req(OP_SPARE, "zZ9a0Az9", 4'd9, 64'h0);
        add_req(OP_PUT, 64'hFF00_0000_0000_4142, 4'd2, 64'h7);
        add_req(OP_GET, 64'h0000_0000_0000_4142, 4'd2, 64'h0);
        add_req(OP_PUT, 64'h0000_0000_0000_2F41, 4'd2, 64'h1);
        add_req(OP_GET, 64'h0000_0000_0000_7B5B, 4'd2, 64'h1);
        add_req(OP_REMOVE, 64'h0000_0000_0000_403A, 4'd2, 64'h0);
        add_req(OP_REMOVE, "zZ9a0Az9", 4'd8, 64'h0);
        add_req(OP_REMOVE, "zZ9a0Az9", 4'd8, 64'h0);
        add_req(OP_GET, "zZ9a0Az9", 4'd8, 64'h0);
        drain();

        // fill a single bucket, remove from the middle
        write_buckets(1);
        for (int i = 0; i < 6; i++) add_req(OP_PUT, pool_key[i], 4'd8, 64'(i));
        add_req(OP_REMOVE, pool_key[1], 4'd8, 64'd0);
        for (int i = 0; i < 6; i++) add_req(OP_GET, pool_key[i], 4'd8, 64'd0);
        drain();
        write_buckets(0);
        add_req(OP_GET, pool_key[0], 4'd8, 64'd0);
        drain();
        write_buckets(127);
        add_req(OP_GET, pool_key[0], 4'd8, 64'd0);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_buckets(64);
                1: write_buckets(3);
                2: write_buckets($urandom_range(1, 64));
                default: write_buckets(64);
            endcase
            for (int i = 0; i < 170; i++)
            begin
                pick = $urandom_range(0, 23);
                k = pool_key[pick];
                n = pool_len[pick];
                if ($urandom_range(0, 9) == 0)
                begin
                    k = {$urandom, $urandom};
                    n = $urandom_range(0, 15);
                end
                else
                    for (int p = n; p < 8; p++) k[8*p +: 8] = 8'($urandom);
                add_req(op_t'($urandom_range(0, 3)), k, n[3:0], {$urandom, $urandom});
            end
            drain();
        end
        $display("%0d requests sent, %0d results checked across bucket counts 0..127",
            accepted, checked);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- chained_hash_table_engine_top.f -----
+incdir+src
src/chte_pkg.sv
src/chte_hash.sv
src/chained_hash_table_engine_top.sv
tb/tb_chained_hash_table_engine_top.sv
